[src/xmodem_receiver_top_macros.svh]
// Assertion macros shared by the receiver's RTL files.
// Depends on nothing; included by the files that carry assertions.
`ifndef XMODEM_RECEIVER_TOP_MACROS_SVH
`define XMODEM_RECEIVER_TOP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define XMR_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define XMR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

[src/xmr_pkg.sv]
// Package of the XMODEM receiver: payload structs, protocol codes and the CRC step.
// Depends on nothing; used by every module of the receiver.
`default_nettype none
package xmr_pkg;
    localparam int DEST_SIZE     = 4096;
    localparam int ATTEMPT_LIMIT = 16;
    localparam int BLOCK_BYTES   = 128;
    localparam int MAX_RESULTS   = 3;
    localparam int CNT_W         = 2;

    localparam logic [7:0] C_SOH  = 8'h01;
    localparam logic [7:0] C_STX  = 8'h02;
    localparam logic [7:0] C_EOT  = 8'h04;
    localparam logic [7:0] C_ACK  = 8'h06;
    localparam logic [7:0] C_NAK  = 8'h15;
    localparam logic [7:0] C_CAN  = 8'h18;
    localparam logic [7:0] C_POLL = 8'h43;

    localparam logic [1:0] REQ_BYTE  = 2'd0;
    localparam logic [1:0] REQ_TICK  = 2'd1;
    localparam logic [1:0] REQ_START = 2'd2;

    localparam logic [1:0] KIND_TX     = 2'd0;
    localparam logic [1:0] KIND_WRITE  = 2'd1;
    localparam logic [1:0] KIND_FINISH = 2'd2;

    localparam logic [1:0] ST_COMPLETE  = 2'd0;
    localparam logic [1:0] ST_CANCELLED = 2'd1;
    localparam logic [1:0] ST_NORESP    = 2'd2;
    localparam logic [1:0] ST_DUPS      = 2'd3;

    localparam logic [1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_RETRANS = 2'd1;
    localparam logic [1:0] CFG_LIMIT   = 2'd2;

    typedef enum logic [1:0] {PH_IDLE, PH_FRAME, PH_CANWAIT} phase_t;
    typedef enum logic [1:0] {PM_C, PM_NAK, PM_NONE} poll_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [7:0]  tx_byte;
        logic [11:0] write_addr;
        logic [7:0]  write_byte;
        logic [1:0]  end_status;
        logic [12:0] received_len;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [15:0] timeout_ticks;
        logic [7:0]  max_retrans;
        logic [12:0] dest_limit;
    } cfg_t;

    // Results of one step, held until the output side has taken them all.
    typedef struct packed {
        logic [CNT_W-1:0] count;
        out_item_t [MAX_RESULTS-1:0] items;
    } burst_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
        end
        return c;
    endfunction
endpackage
`default_nettype wire

[src/xmodem_receiver_top.sv]
// XMODEM receiver top level: configuration registers, core and result buffer.
// Depends on xmr_pkg, xmr_core and xmr_out.
//
// Input items (received byte, timer tick or start request) arrive on the s_
// channel; results (bytes to transmit, destination writes, session end) leave
// on the m_ channel, each carrying last on the final result of its item.
// An item is processed in the cycle it is accepted by single-pass logic; its
// up to three results sit in the result buffer from the next cycle and leave
// one per transfer, each as the receiver accepts it with m_ready high.
// Throughput is one item per cycle while items give at most one result and
// the receiver takes every result; an item with k results holds s_ready low
// until k-1 of them have been taken, as the buffer frees only on the last.
// The configuration port writes timeout_ticks, max_retrans and dest_limit at
// indices 0 to 2 on any clock with cfg_we high.
// Reset (aresetn low, synchronous) returns the protocol to idle, clears the
// buffer and reloads the register defaults. A stalled receiver holds results
// in the buffer and back-pressures the input side through s_ready.
`default_nettype none
module xmodem_receiver_top (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  xmr_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output xmr_pkg::out_item_t  m_data,
    input  wire logic           cfg_we,
    input  wire logic [1:0]     cfg_index,
    input  wire logic [15:0]    cfg_data
);
    xmr_pkg::cfg_t cfg_reg;
    xmr_pkg::burst_t burst;
    logic can_load;
    logic step_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.timeout_ticks <= 16'd8000;
            cfg_reg.max_retrans   <= 8'd25;
            cfg_reg.dest_limit    <= 13'd4096;
        end else if (cfg_we) begin
            unique case (cfg_index)
                xmr_pkg::CFG_TIMEOUT: cfg_reg.timeout_ticks <= cfg_data;
                xmr_pkg::CFG_RETRANS: cfg_reg.max_retrans   <= cfg_data[7:0];
                xmr_pkg::CFG_LIMIT:   cfg_reg.dest_limit    <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    assign s_ready = can_load;
    assign step_en = s_valid && s_ready;

    xmr_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .item    (s_data),
        .cfg     (cfg_reg),
        .burst   (burst)
    );

    xmr_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (step_en),
        .burst    (burst),
        .can_load (can_load),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );
endmodule
`default_nettype wire

[src/xmr_core.sv]
// Protocol engine: one input item in, up to three results out per cycle.
// Depends on xmr_pkg and the assertion macros header.
`default_nettype none
`include "xmodem_receiver_top_macros.svh"
module xmr_core (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           step_en,
    input  xmr_pkg::in_item_t   item,
    input  xmr_pkg::cfg_t       cfg,
    output xmr_pkg::burst_t     burst
);
    xmr_pkg::phase_t phase_reg, phase_next;
    xmr_pkg::poll_t  poll_reg, poll_next;
    logic        crc_mode_reg, crc_mode_next;
    logic [7:0]  exp_blk_reg, exp_blk_next;
    logic [12:0] clen_reg, clen_next;
    logic [4:0]  att_reg, att_next;
    logic [7:0]  dup_reg, dup_next;
    logic [7:0]  fidx_reg, fidx_next;
    logic [7:0]  first_reg, first_next;
    logic [7:0]  blk_reg, blk_next;
    logic [7:0]  inv_reg, inv_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  sum_reg, sum_next;
    logic [15:0] trl_reg, trl_next;
    logic [15:0] tick_reg, tick_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= xmr_pkg::PH_IDLE;
            poll_reg <= xmr_pkg::PM_C;
            crc_mode_reg <= 1'b0;
            exp_blk_reg <= 8'd1;
            clen_reg <= '0;
            att_reg <= '0;
            dup_reg <= 8'd25;
            fidx_reg <= '0;
            first_reg <= '0;
            blk_reg <= '0;
            inv_reg <= '0;
            crc_reg <= '0;
            sum_reg <= '0;
            trl_reg <= '0;
            tick_reg <= '0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            poll_reg <= poll_next;
            crc_mode_reg <= crc_mode_next;
            exp_blk_reg <= exp_blk_next;
            clen_reg <= clen_next;
            att_reg <= att_next;
            dup_reg <= dup_next;
            fidx_reg <= fidx_next;
            first_reg <= first_next;
            blk_reg <= blk_next;
            inv_reg <= inv_next;
            crc_reg <= crc_next;
            sum_reg <= sum_next;
            trl_reg <= trl_next;
            tick_reg <= tick_next;
        end
    end

    always_comb begin
        logic [12:0] lim;
        logic [12:0] cnt;
        logic [12:0] addr;
        logic [7:0]  idx;
        logic [7:0]  b;
        logic [7:0]  goal;
        logic        do_close;
        logic        do_retry;
        logic        ok;
        logic [1:0]  n;
        xmr_pkg::out_item_t r [3];
        logic [1:0]  rk [3];
        logic [7:0]  rt [3];
        logic [11:0] ra [3];
        logic [7:0]  rb [3];
        logic [1:0]  rs [3];

        phase_next = phase_reg; poll_next = poll_reg; crc_mode_next = crc_mode_reg;
        exp_blk_next = exp_blk_reg; clen_next = clen_reg; att_next = att_reg;
        dup_next = dup_reg; fidx_next = fidx_reg; first_next = first_reg;
        blk_next = blk_reg; inv_next = inv_reg; crc_next = crc_reg; sum_next = sum_reg;
        trl_next = trl_reg; tick_next = tick_reg;
        n = '0; do_close = 1'b0; do_retry = 1'b0; ok = 1'b0;
        b = item.rx_byte; idx = fidx_reg; addr = '0; cnt = '0;
        for (int i = 0; i < 3; i++) begin
            rk[i] = '0; rt[i] = '0; ra[i] = '0; rb[i] = '0; rs[i] = '0;
        end
        lim = (cfg.dest_limit < 13'(xmr_pkg::DEST_SIZE)) ? cfg.dest_limit
                                                         : 13'(xmr_pkg::DEST_SIZE);
        goal = 8'(xmr_pkg::BLOCK_BYTES + 4)
             + {7'd0, (crc_mode_reg || poll_reg == xmr_pkg::PM_C)};

        case (item.req_type)
            xmr_pkg::REQ_START: begin
                poll_next = xmr_pkg::PM_C; crc_mode_next = 1'b0; exp_blk_next = 8'd1;
                clen_next = '0; att_next = '0; dup_next = cfg.max_retrans;
                first_next = '0; blk_next = '0; inv_next = '0;
                rk[0] = xmr_pkg::KIND_TX; rt[0] = xmr_pkg::C_POLL; n = 2'd1;
                phase_next = xmr_pkg::PH_FRAME; fidx_next = '0; tick_next = '0;
                crc_next = '0; sum_next = '0; trl_next = '0;
            end
            xmr_pkg::REQ_BYTE: begin
                if (phase_reg == xmr_pkg::PH_FRAME) begin
                    if (idx == 8'd0) first_next = b;
                    else if (idx == 8'd1) blk_next = b;
                    else if (idx == 8'd2) inv_next = b;
                    else if (idx < 8'(3 + xmr_pkg::BLOCK_BYTES)) begin
                        addr = clen_reg + 13'(idx - 8'd3);
                        crc_next = xmr_pkg::crc_byte(crc_reg, b);
                        sum_next = sum_reg + b;
                        if (first_reg == xmr_pkg::C_SOH && addr < lim) begin
                            rk[0] = xmr_pkg::KIND_WRITE; ra[0] = addr[11:0];
                            rb[0] = b; n = 2'd1;
                        end
                    end else begin
                        trl_next = {trl_reg[7:0], b};
                    end
                    if (fidx_reg != 8'hFF) fidx_next = fidx_reg + 8'd1;
                    if ((idx == 8'd0 && (b == xmr_pkg::C_ACK || b == xmr_pkg::C_NAK
                         || b == xmr_pkg::C_CAN || b == xmr_pkg::C_EOT))
                        || fidx_next >= goal) do_close = 1'b1;
                end else if (phase_reg == xmr_pkg::PH_CANWAIT) begin
                    if (b == xmr_pkg::C_CAN) begin
                        phase_next = xmr_pkg::PH_IDLE;
                        rk[0] = xmr_pkg::KIND_FINISH; rt[0] = xmr_pkg::C_ACK;
                        rs[0] = xmr_pkg::ST_CANCELLED; n = 2'd1;
                    end else do_retry = 1'b1;
                end
            end
            xmr_pkg::REQ_TICK: begin
                if (phase_reg != xmr_pkg::PH_IDLE) begin
                    if (tick_reg != 16'hFFFF) tick_next = tick_reg + 16'd1;
                    if (tick_next >= cfg.timeout_ticks) begin
                        if (phase_reg == xmr_pkg::PH_FRAME) do_close = 1'b1;
                        else do_retry = 1'b1;
                    end
                end
            end
            default: ;
        endcase

        // Frame close works on the updated frame fields.
        if (do_close) begin
            if (fidx_next == 8'd0) do_retry = 1'b1;
            else if (first_next == xmr_pkg::C_SOH) begin
                if (poll_reg == xmr_pkg::PM_C) crc_mode_next = 1'b1;
                poll_next = xmr_pkg::PM_NONE;
                ok = fidx_next == goal && blk_next == ~inv_next
                     && (blk_next == exp_blk_reg || blk_next == exp_blk_reg - 8'd1)
                     && (crc_mode_next ? (crc_next == trl_next)
                                       : (sum_next == trl_next[7:0]));
                att_next = '0;
                phase_next = xmr_pkg::PH_FRAME; fidx_next = '0; tick_next = '0;
                crc_next = '0; sum_next = '0; trl_next = '0;
                rk[n] = xmr_pkg::KIND_TX;
                if (!ok) begin
                    rt[n] = xmr_pkg::C_NAK; n = n + 2'd1;
                end else begin
                    logic cancel;
                    cancel = 1'b0;
                    if (blk_next == exp_blk_reg) begin
                        cnt = (lim > clen_reg) ? lim - clen_reg : 13'd0;
                        if (cnt > 13'(xmr_pkg::BLOCK_BYTES)) cnt = 13'(xmr_pkg::BLOCK_BYTES);
                        clen_next = clen_reg + cnt;
                        exp_blk_next = exp_blk_reg + 8'd1;
                        if (cfg.max_retrans == 8'd0) begin
                            dup_next = '0; cancel = 1'b1;
                        end else dup_next = cfg.max_retrans;
                    end else if (dup_reg <= 8'd1) begin
                        dup_next = '0; cancel = 1'b1;
                    end else dup_next = dup_reg - 8'd1;
                    if (cancel) begin
                        phase_next = xmr_pkg::PH_IDLE;
                        rt[0] = xmr_pkg::C_CAN; rk[0] = xmr_pkg::KIND_TX;
                        rt[1] = xmr_pkg::C_CAN; rk[1] = xmr_pkg::KIND_TX;
                        rt[2] = xmr_pkg::C_CAN; rk[2] = xmr_pkg::KIND_FINISH;
                        rs[2] = xmr_pkg::ST_DUPS;
                        n = 2'd3;
                    end else begin
                        rt[n] = xmr_pkg::C_ACK; n = n + 2'd1;
                    end
                end
            end else if (first_next == xmr_pkg::C_STX || first_next == xmr_pkg::C_EOT) begin
                phase_next = xmr_pkg::PH_IDLE;
                rk[n] = xmr_pkg::KIND_FINISH;
                rt[n] = (first_next == xmr_pkg::C_STX) ? xmr_pkg::C_CAN : xmr_pkg::C_ACK;
                rs[n] = (first_next == xmr_pkg::C_STX) ? xmr_pkg::ST_CANCELLED
                                                       : xmr_pkg::ST_COMPLETE;
                n = n + 2'd1;
            end else if (first_next == xmr_pkg::C_CAN) begin
                phase_next = xmr_pkg::PH_CANWAIT; tick_next = '0;
            end else do_retry = 1'b1;
        end

        if (do_retry) begin
            att_next = att_reg + 5'd1;
            phase_next = xmr_pkg::PH_FRAME; fidx_next = '0; tick_next = '0;
            crc_next = '0; sum_next = '0; trl_next = '0;
            if (att_next < 5'(xmr_pkg::ATTEMPT_LIMIT)) begin
                if (poll_reg != xmr_pkg::PM_NONE) begin
                    rk[n] = xmr_pkg::KIND_TX;
                    rt[n] = (poll_reg == xmr_pkg::PM_C) ? xmr_pkg::C_POLL : xmr_pkg::C_NAK;
                    n = n + 2'd1;
                end
            end else if (poll_reg == xmr_pkg::PM_C) begin
                poll_next = xmr_pkg::PM_NAK; att_next = '0;
                rk[n] = xmr_pkg::KIND_TX; rt[n] = xmr_pkg::C_NAK; n = n + 2'd1;
            end else begin
                phase_next = xmr_pkg::PH_IDLE;
                rk[0] = xmr_pkg::KIND_TX; rt[0] = xmr_pkg::C_CAN;
                rk[1] = xmr_pkg::KIND_TX; rt[1] = xmr_pkg::C_CAN;
                rk[2] = xmr_pkg::KIND_FINISH; rt[2] = xmr_pkg::C_CAN;
                rs[2] = xmr_pkg::ST_NORESP; n = 2'd3;
            end
        end

        for (int i = 0; i < 3; i++) begin
            r[i].out_kind = rk[i]; r[i].tx_byte = rt[i]; r[i].write_addr = ra[i];
            r[i].write_byte = rb[i]; r[i].end_status = rs[i];
            r[i].received_len = clen_next;
            r[i].last = (2'(i + 1) == n);
            burst.items[i] = r[i];
        end
        burst.count = n;
    end

    `XMR_ASSERT_NEXT(a_idle_holds, aclk, aresetn,
        step_en && item.req_type != xmr_pkg::REQ_START && phase_reg == xmr_pkg::PH_IDLE,
        phase_reg == xmr_pkg::PH_IDLE, "idle phase left without a start request")
    `XMR_ASSERT_IMP(a_len_bound, aclk, aresetn, 1'b1,
        clen_reg <= 13'(xmr_pkg::DEST_SIZE), "committed length beyond destination size")
    `XMR_ASSERT_IMP(a_att_bound, aclk, aresetn, 1'b1,
        att_reg <= 5'(xmr_pkg::ATTEMPT_LIMIT), "attempt counter beyond limit")
endmodule
`default_nettype wire

[src/xmr_out.sv]
// Result buffer: holds one step's burst and hands its items out one per transfer.
// Depends on xmr_pkg and the assertion macros header.
`default_nettype none
`include "xmodem_receiver_top_macros.svh"
module xmr_out (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        load,
    input  xmr_pkg::burst_t  burst,
    output logic             can_load,
    output logic             m_valid,
    input  wire logic        m_ready,
    output xmr_pkg::out_item_t m_data
);
    xmr_pkg::burst_t buf_reg;
    logic [xmr_pkg::CNT_W-1:0] pos_reg, pos_next;
    logic [xmr_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic done;

    assign m_valid = cnt_reg != '0;
    assign m_data  = buf_reg.items[pos_reg];
    // The final item leaving frees the buffer in the same cycle.
    assign done     = m_valid && m_ready && (pos_reg + 2'd1 == cnt_reg);
    assign can_load = !m_valid || done;

    always_comb begin
        pos_next = pos_reg;
        cnt_next = cnt_reg;
        if (m_valid && m_ready) pos_next = pos_reg + 2'd1;
        if (done) begin
            cnt_next = '0; pos_next = '0;
        end
        if (load && can_load) begin
            cnt_next = burst.count; pos_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            cnt_reg <= '0;
        end else begin
            pos_reg <= pos_next;
            cnt_reg <= cnt_next;
        end
        if (load && can_load) buf_reg <= burst;
    end

    `XMR_ASSERT_IMP(a_pos_in_range, aclk, aresetn, m_valid, pos_reg < cnt_reg,
        "read position beyond burst")
    `XMR_ASSERT_IMP(a_last_flag, aclk, aresetn, m_valid,
        m_data.last == (pos_reg + 2'd1 == cnt_reg), "last flag out of place")
    `XMR_ASSERT_NEXT(a_hold_result, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_data), "waiting result changed before its transfer")
endmodule
`default_nettype wire
